// File: hw/rtl/arb_pkg.sv
// ----------------------------------------------------------------------------
// arb_pkg
// Shared types and codes for the affine raster bilinear sampler.
// ----------------------------------------------------------------------------
package arb_pkg;

    // request kinds (tuser on the input side)
    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_BILINEAR = 2'd2;

    // result status (tuser on the output side)
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEGEN = 2'd1;
    localparam logic [1:0] ST_OOB   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_CELL_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CELL_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SKEW_ROW    = 3'd4;
    localparam logic [2:0] REG_SKEW_COL    = 3'd5;
    localparam logic [2:0] REG_RASTER_DIMS = 3'd6;
    localparam logic [2:0] REG_NODATA_WORD = 3'd7;

    localparam int COORD_W = 48;   // Q24.24 coordinates and coefficients
    localparam int DELTA_W = 49;   // coordinate minus origin
    localparam int NUM_W   = 100;  // cross-product sums
    localparam int DEN_W   = 96;   // |determinant|
    localparam int QW      = 13;   // integer pixel position
    localparam int FRAC_W  = 16;   // blend fraction
    localparam int WGT_W   = 33;   // blend weight, up to 2^32
    localparam int ELEV_W  = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_NORM,
        S_DIVS,
        S_DIV,
        S_CHK,
        S_WGT,
        S_RD,
        S_DRAIN,
        S_FIN,
        S_OUT
    } arb_state_t;

    // pixel position from one divider
    typedef struct packed {
        logic              inb;
        logic [QW-1:0]     quo;
        logic [QW:0]       near;
        logic [FRAC_W-1:0] frac;
    } arb_loc_t;

    // sequencer controls
    typedef struct packed {
        logic slot_take;
        logic mem_we;
        logic mac_start;
        logic div_start;
        logic mem_re;
        logic out_load;
    } arb_ctl_t;

endpackage

// File: hw/rtl/arb_mac.sv
// ----------------------------------------------------------------------------
// arb_mac
// Computes a0*b0 - a1*b1, one 49x17 partial product a cycle.
// ----------------------------------------------------------------------------
module arb_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [arb_pkg::DELTA_W-1:0]  a0,
    input  logic signed [arb_pkg::COORD_W-1:0]  b0,
    input  logic signed [arb_pkg::DELTA_W-1:0]  a1,
    input  logic signed [arb_pkg::COORD_W-1:0]  b1,
    output logic signed [arb_pkg::NUM_W-1:0]    acc,
    output logic                                done
);
    import arb_pkg::*;

    logic [2:0]                busy_cnt_reg;
    logic [2:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [NUM_W-1:0]   acc_reg;
    logic signed [NUM_W-1:0]   acc_next;
    logic                      sub_phase;
    logic [1:0]                digit;
    logic signed [DELTA_W-1:0] op_a;
    logic signed [COORD_W-1:0] op_b;
    logic signed [16:0]        dig;
    logic signed [65:0]        pp;
    logic signed [NUM_W-1:0]   pp_ext;
    logic signed [NUM_W-1:0]   pp_sh;

    assign busy_cnt_reg = cnt_reg;
    assign sub_phase    = (busy_cnt_reg >= 3'd3);
    assign digit        = sub_phase ? 2'(busy_cnt_reg - 3'd3) : busy_cnt_reg[1:0];
    assign op_a         = sub_phase ? a1 : a0;
    assign op_b         = sub_phase ? b1 : b0;

    always_comb
    begin
        case (digit)
            2'd0:    dig = $signed({1'b0, op_b[15:0]});
            2'd1:    dig = $signed({1'b0, op_b[31:16]});
            default: dig = $signed({op_b[47], op_b[47:32]});
        endcase
        pp     = op_a * dig;
        pp_ext = NUM_W'(pp);
        case (digit)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext <<< 16;
            default: pp_sh = pp_ext <<< 32;
        endcase
        acc_next = sub_phase ? acc_reg - pp_sh : acc_reg + pp_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            acc_reg <= '0;
        else if (busy_reg)
            acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// File: hw/rtl/arb_div.sv
// ----------------------------------------------------------------------------
// arb_div
// Restoring divider: 13 integer steps then 16 fraction steps, one a cycle.
// ----------------------------------------------------------------------------
module arb_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [arb_pkg::NUM_W-1:0]  num,
    input  logic [arb_pkg::DEN_W-1:0]         den,
    input  logic [arb_pkg::QW-1:0]            lim,
    output logic                              done,
    output arb_pkg::arb_loc_t                 loc
);
    import arb_pkg::*;

    localparam int REM_W = DEN_W + QW + 3;
    localparam int STEPS = QW + FRAC_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [REM_W-1:0]  dsh_reg;
    logic [REM_W-1:0]  den_ext;
    logic [REM_W-1:0]  num_ext;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  cmpv;
    logic              ge;
    logic              int_phase;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              oob_reg;
    logic [QW-1:0]     quo_reg;
    logic [FRAC_W-1:0] frac_reg;

    assign den_ext   = {{(REM_W-DEN_W){1'b0}}, den};
    assign num_ext   = {{(REM_W-NUM_W){1'b0}}, num};
    assign int_phase = (cnt_reg < CNT_W'(QW));

    always_comb
    begin
        trial    = int_phase ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
        cmpv     = int_phase ? dsh_reg : den_ext;
        ge       = (trial >= cmpv);
        rem_next = ge ? trial - cmpv : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num_ext;
            dsh_reg  <= den_ext << (QW - 1);
            oob_reg  <= num[NUM_W-1] || (num_ext >= (den_ext << QW));
            quo_reg  <= '0;
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            if (int_phase)
            begin
                quo_reg <= {quo_reg[QW-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
            end
            else
            begin
                frac_reg <= {frac_reg[FRAC_W-2:0], ge};
            end
        end
    end

    // first fraction bit is the round-half-up bit of the nearest pixel
    always_comb
    begin
        loc.inb  = !oob_reg && (quo_reg < lim);
        loc.quo  = quo_reg;
        loc.near = {1'b0, quo_reg} + {{QW{1'b0}}, frac_reg[FRAC_W-1]};
        loc.frac = frac_reg;
    end

    assign done = done_reg;

endmodule

// File: hw/rtl/affine_raster_bilinear_sampler_core.sv
// ----------------------------------------------------------------------------
// affine_raster_bilinear_sampler_core
// Elevation raster with inverse affine mapping and nearest/bilinear sampling.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tuser: command; tdata: index, load_word, x, y
//  m_axis    out  tvalid/tready         tuser: status; tdata: elevation
//  cfg       in   cfg_we (no stall)     cfg_addr, cfg_wdata
//
//  A load request is handled in the sequencer's idle state; the input slot
//  holds one request and takes no other until the sequencer has taken it. A
//  sample request passes through the multiply, the 29-step restoring divider,
//  one raster read per neighbor and the drain of the blend pipe. A degenerate
//  transform skips the divider and the raster reads; an off-raster point skips
//  the raster reads. One request waits in the input slot while another is in
//  the sequencer, and a finished result waits in the output register.
//  Reset clears control state and loads a north-up unit-cell geotransform; the
//  raster memory itself holds no reset value.
//
module affine_raster_bilinear_sampler_core #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,   // pixel_index, load_word, coord_x, coord_y
    input  logic [1:0]   s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // elevation
    output logic [1:0]   m_axis_tuser,   // status
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata
);
    import arb_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [63:0] EPS = (2 * COORD_FRAC_BITS < 64)
        ? (64'd1 << (2 * COORD_FRAC_BITS)) / 64'd10000000000
        : 64'hFFFF_FFFF_FFFF_FFFF / 64'd10000000000;

    // configuration
    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic signed [COORD_W-1:0] cell_width_reg, cell_height_reg;
    logic signed [COORD_W-1:0] skew_row_reg, skew_col_reg;
    logic [17:0]               raster_dims_reg;
    logic [32:0]               nodata_word_reg;

    // input slot
    logic                      slot_valid_reg;
    logic [1:0]                slot_cmd_reg;
    logic [15:0]               slot_idx_reg;
    logic [31:0]               slot_val_reg;
    logic signed [COORD_W-1:0] slot_cx_reg, slot_cy_reg;

    // sequencer
    arb_state_t state_reg, state_next;
    arb_ctl_t   ctl;

    logic                      bilin_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [NUM_W-1:0]   acc_det, acc_nx, acc_ny;
    logic [2:0]                mac_done;
    logic [NUM_W-1:0]          det_mag;
    logic                      degen;
    logic [DEN_W-1:0]          det_reg;
    logic signed [NUM_W-1:0]   nx_reg, ny_reg;
    logic [1:0]                div_done;
    arb_loc_t                  loc_x, loc_y;
    logic [QW-1:0]             dim_w, dim_h;
    logic [QW-1:0]             col0_reg, col1_reg, row0_reg, row1_reg;
    logic [QW:0]               xn_clamp, yn_clamp;
    logic [FRAC_W-1:0]         fx_reg, fy_reg;
    logic [FRAC_W:0]           gx, gy;
    logic [WGT_W-1:0]          wgt_reg [4];
    logic [ADDR_W-1:0]         addr_reg [4];
    logic [1:0]                rd_cnt_reg;
    logic [1:0]                rd_last_reg;

    // raster memory and blend pipe
    logic [ELEV_W-1:0]         mem [DEPTH];
    logic [ELEV_W-1:0]         mem_q_reg;
    logic                      rd_v_reg;
    logic [1:0]                rd_k_reg;
    logic signed [63:0]        prod_reg;
    logic                      prod_v_reg;
    logic [63:0]               blend_reg;
    logic [63:0]               rounded;
    logic [31:0]               idx_ext;
    logic                      load_in_range;

    // result and output
    logic [1:0]                res_status_reg;
    logic [ELEV_W-1:0]         res_elev_reg;
    logic                      out_valid_reg;
    logic [1:0]                out_status_reg;
    logic [ELEV_W-1:0]         out_elev_reg;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= 48'sh0001_0000_0000;
            cell_width_reg  <= 48'sh0000_0100_0000;
            cell_height_reg <= -48'sh0000_0100_0000;
            skew_row_reg    <= '0;
            skew_col_reg    <= '0;
            raster_dims_reg <= 18'd131328;
            nodata_word_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_wdata;
                REG_CELL_HEIGHT: cell_height_reg <= cfg_wdata;
                REG_SKEW_ROW:    skew_row_reg    <= cfg_wdata;
                REG_SKEW_COL:    skew_col_reg    <= cfg_wdata;
                REG_RASTER_DIMS: raster_dims_reg <= cfg_wdata[17:0];
                REG_NODATA_WORD: nodata_word_reg <= cfg_wdata[32:0];
                default:         ;
            endcase
        end
    end

    // dimensions saturate at the memory size
    assign dim_w = ({4'd0, raster_dims_reg[8:0]} > QW'(MAX_WIDTH))
                 ? QW'(MAX_WIDTH) : {4'd0, raster_dims_reg[8:0]};
    assign dim_h = ({4'd0, raster_dims_reg[17:9]} > QW'(MAX_HEIGHT))
                 ? QW'(MAX_HEIGHT) : {4'd0, raster_dims_reg[17:9]};

    // ------------------------------------------------------------------
    // input slot
    // ------------------------------------------------------------------
    assign s_axis_tready = !slot_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            slot_valid_reg <= 1'b1;
        else if (ctl.slot_take)
            slot_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            slot_cmd_reg <= s_axis_tuser;
            slot_idx_reg <= s_axis_tdata[15:0];
            slot_val_reg <= s_axis_tdata[47:16];
            slot_cx_reg  <= s_axis_tdata[95:48];
            slot_cy_reg  <= s_axis_tdata[143:96];
        end
    end

    assign idx_ext       = {16'd0, slot_idx_reg};
    assign load_in_range = (idx_ext < 32'(DEPTH));

    // ------------------------------------------------------------------
    // arithmetic units: det, x numerator, y numerator
    // ------------------------------------------------------------------
    arb_mac u_mac_det (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.mac_start),
        .a0    (DELTA_W'(cell_width_reg)),
        .b0    (cell_height_reg),
        .a1    (DELTA_W'(skew_row_reg)),
        .b1    (skew_col_reg),
        .acc   (acc_det),
        .done  (mac_done[0])
    );

    arb_mac u_mac_nx (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.mac_start),
        .a0    (dx_reg),
        .b0    (cell_height_reg),
        .a1    (dy_reg),
        .b1    (skew_row_reg),
        .acc   (acc_nx),
        .done  (mac_done[1])
    );

    arb_mac u_mac_ny (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.mac_start),
        .a0    (dy_reg),
        .b0    (cell_width_reg),
        .a1    (dx_reg),
        .b1    (skew_col_reg),
        .acc   (acc_ny),
        .done  (mac_done[2])
    );

    assign det_mag = acc_det[NUM_W-1] ? NUM_W'(-acc_det) : NUM_W'(acc_det);
    assign degen   = (det_mag <= {{(NUM_W-64){1'b0}}, EPS});

    arb_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (nx_reg),
        .den   (det_reg),
        .lim   (dim_w),
        .done  (div_done[0]),
        .loc   (loc_x)
    );

    arb_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (ny_reg),
        .den   (det_reg),
        .lim   (dim_h),
        .done  (div_done[1]),
        .loc   (loc_y)
    );

    // nearest pixel clamped to the last column/row
    assign xn_clamp = (loc_x.near >= {1'b0, dim_w}) ? {1'b0, dim_w - QW'(1)} : loc_x.near;
    assign yn_clamp = (loc_y.near >= {1'b0, dim_h}) ? {1'b0, dim_h - QW'(1)} : loc_y.near;

    assign gx = 17'h10000 - {1'b0, fx_reg};
    assign gy = 17'h10000 - {1'b0, fy_reg};

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (slot_valid_reg && slot_cmd_reg != CMD_LOAD)
                    state_next = S_PREP;
            S_PREP:  state_next = S_MUL;
            S_MUL:
                if (&mac_done)
                    state_next = S_NORM;
            S_NORM:  state_next = degen ? S_OUT : S_DIVS;
            S_DIVS:  state_next = S_DIV;
            S_DIV:
                if (&div_done)
                    state_next = S_CHK;
            S_CHK:   state_next = (loc_x.inb && loc_y.inb) ? S_WGT : S_OUT;
            S_WGT:   state_next = S_RD;
            S_RD:
                if (rd_cnt_reg == rd_last_reg)
                    state_next = S_DRAIN;
            S_DRAIN:
                if (!rd_v_reg && !prod_v_reg)
                    state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:
                if (!out_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: controls
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.slot_take = slot_valid_reg;
                ctl.mem_we    = slot_valid_reg && (slot_cmd_reg == CMD_LOAD)
                              && load_in_range;
            end
            S_PREP:  ctl.mac_start = 1'b1;
            S_DIVS:  ctl.div_start = 1'b1;
            S_RD:    ctl.mem_re    = 1'b1;
            S_OUT:   ctl.out_load  = !out_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                bilin_reg <= (slot_cmd_reg == CMD_BILINEAR);
                dx_reg    <= DELTA_W'(slot_cx_reg) - DELTA_W'(origin_x_reg);
                dy_reg    <= DELTA_W'(slot_cy_reg) - DELTA_W'(origin_y_reg);
            end
            S_NORM:
            begin
                // fold the determinant sign into the numerators
                det_reg        <= det_mag[DEN_W-1:0];
                nx_reg         <= acc_det[NUM_W-1] ? -acc_nx : acc_nx;
                ny_reg         <= acc_det[NUM_W-1] ? -acc_ny : acc_ny;
                res_status_reg <= ST_DEGEN;
                res_elev_reg   <= '0;
            end
            S_CHK:
            begin
                res_status_reg <= ST_OOB;
                res_elev_reg   <= '0;
                if (bilin_reg)
                begin
                    col0_reg <= loc_x.quo;
                    row0_reg <= loc_y.quo;
                    col1_reg <= (loc_x.quo + QW'(1) >= dim_w) ? loc_x.quo
                                                              : loc_x.quo + QW'(1);
                    row1_reg <= (loc_y.quo + QW'(1) >= dim_h) ? loc_y.quo
                                                              : loc_y.quo + QW'(1);
                    fx_reg   <= loc_x.frac;
                    fy_reg   <= loc_y.frac;
                end
                else
                begin
                    // nearest: one read with full weight
                    col0_reg <= xn_clamp[QW-1:0];
                    row0_reg <= yn_clamp[QW-1:0];
                    col1_reg <= xn_clamp[QW-1:0];
                    row1_reg <= yn_clamp[QW-1:0];
                    fx_reg   <= '0;
                    fy_reg   <= '0;
                end
            end
            S_WGT:
            begin
                wgt_reg[0]  <= WGT_W'(gx) * WGT_W'(gy);
                wgt_reg[1]  <= WGT_W'(fx_reg) * WGT_W'(gy);
                wgt_reg[2]  <= WGT_W'(gx) * WGT_W'(fy_reg);
                wgt_reg[3]  <= WGT_W'(fx_reg) * WGT_W'(fy_reg);
                addr_reg[0] <= ADDR_W'(32'(row0_reg) * MAX_WIDTH + 32'(col0_reg));
                addr_reg[1] <= ADDR_W'(32'(row0_reg) * MAX_WIDTH + 32'(col1_reg));
                addr_reg[2] <= ADDR_W'(32'(row1_reg) * MAX_WIDTH + 32'(col0_reg));
                addr_reg[3] <= ADDR_W'(32'(row1_reg) * MAX_WIDTH + 32'(col1_reg));
                rd_last_reg <= bilin_reg ? 2'd3 : 2'd0;
            end
            S_FIN:
            begin
                if (nodata_word_reg[32] && rounded[63:32] == nodata_word_reg[31:0])
                begin
                    res_status_reg <= ST_OOB;
                    res_elev_reg   <= '0;
                end
                else
                begin
                    res_status_reg <= ST_OK;
                    res_elev_reg   <= rounded[63:32];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_cnt_reg <= '0;
        else if (state_reg == S_WGT)
            rd_cnt_reg <= '0;
        else if (ctl.mem_re)
            rd_cnt_reg <= rd_cnt_reg + 2'd1;
    end

    // raster memory: one write port for loads, one read port for samples
    always_ff @(posedge clk)
    begin
        if (ctl.mem_we)
            mem[idx_ext[ADDR_W-1:0]] <= slot_val_reg;
        if (ctl.mem_re)
            mem_q_reg <= mem[addr_reg[rd_cnt_reg]];
    end

    // blend pipe: read data -> product -> accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= ctl.mem_re;
            prod_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_k_reg <= rd_cnt_reg;
        if (rd_v_reg)
            prod_reg <= 64'($signed(mem_q_reg)) * $signed({31'd0, wgt_reg[rd_k_reg]});
        if (state_reg == S_WGT)
            blend_reg <= '0;
        else if (prod_v_reg)
            blend_reg <= blend_reg + prod_reg;
    end

    // round half up, then arithmetic shift by 32
    assign rounded = blend_reg + 64'h0000_0000_8000_0000;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_elev_reg   <= res_elev_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = out_elev_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_elev_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("nonzero elevation on error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_DEGEN
                          || m_axis_tuser == ST_OOB)
        else $error("undefined status code");

    a_mac_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done[0] == mac_done[1] && mac_done[1] == mac_done[2])
        else $error("multiply units out of step");

    a_no_load_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mem_we |-> !rd_v_reg && !prod_v_reg)
        else $error("raster load while a blend is in flight");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the affine raster bilinear sampler core.
// Builds its own copy of the raster and geotransform, predicts status and
// elevation for every sample request, and compares them with the results on
// the output stream. Directed corner cases come first, then randomized
// traffic under several idle/stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import arb_pkg::*;

    localparam int          RASTER_W    = 256;     // row pitch of the raster store
    localparam int          RASTER_H    = 256;
    localparam int          BLEND_BITS  = 16;
    localparam longint      DET_EPS     = 28147;   // floor(2^48 / 1e10)
    localparam int          DRAIN_WAIT  = 120;     // cycles past the last result
    localparam longint      CYCLE_LIMIT = 3000000;
    localparam logic [1:0]  CMD_NEAREST     = 2'd1;
    localparam logic [1:0]  CMD_NEAREST_ALT = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] elevation;
    } sample_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;    // pixel_index, load_word, coord_x, coord_y
    logic [1:0]   s_axis_tuser;    // command
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;    // elevation
    logic [1:0]   m_axis_tuser;    // status
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [47:0]  cfg_wdata;

    // predictor state: raster copy, write tracking and geotransform registers
    logic [31:0]        raster_copy [RASTER_W*RASTER_H];
    bit                 written     [RASTER_W*RASTER_H];
    logic signed [47:0] g_ox, g_oy, g_cw, g_ch, g_sr, g_sc;
    logic [17:0]        g_dims;
    logic [32:0]        g_nodata;

    sample_result_t pending_results[$];

    int     errors;
    int     loads_sent;
    int     samples_sent;
    int     results_seen;
    int     idle_pct;        // sender idle chance per cycle, percent
    int     stall_pct;       // receiver stall chance per cycle, percent
    int     hold_cycles;     // long output hold-off, counted down by the receiver
    longint cycle_count;

    affine_raster_bilinear_sampler_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic signed [127:0] pixel_at(input int col, input int row);
        logic signed [127:0] p;
        p = $signed(raster_copy[row*RASTER_W + col]);
        return p;
    endfunction

    // integer part, rounded position and blend fraction of num/den (den > 0);
    // zero when the ratio lies outside [0, n)
    function automatic bit pixel_position(input logic signed [127:0] num,
                                          input logic signed [127:0] den,
                                          input int n, output int whole,
                                          output int rounded, output int frac);
        logic signed [127:0] rem;
        whole = 0;
        rounded = 0;
        frac = 0;
        if (num < 0 || num >= den * n)
            return 1'b0;
        whole = num / den;
        rem = num - den * whole;
        rounded = whole + ((rem * 2 >= den) ? 1 : 0);
        frac = (rem <<< BLEND_BITS) / den;
        return 1'b1;
    endfunction

    function automatic void predict_sample(input bit blend,
                                           input logic signed [47:0] cx,
                                           input logic signed [47:0] cy,
                                           output sample_result_t res);
        logic signed [127:0] cw, ch, sr, sc, ax, ay, dx, dy, det, nx, ny, sum;
        int     w, h, qx, qy, rx, ry, fx, fy, x1, y1;
        longint gx, gy;
        logic [31:0] v;
        res.status = ST_OK;
        res.elevation = '0;
        w = g_dims[8:0];
        h = g_dims[17:9];
        if (w > RASTER_W) w = RASTER_W;
        if (h > RASTER_H) h = RASTER_H;
        cw = g_cw;
        ch = g_ch;
        sr = g_sr;
        sc = g_sc;
        ax = cx;
        ay = cy;
        dx = ax - g_ox;
        dy = ay - g_oy;
        det = cw * ch - sr * sc;
        if ((det < 0 ? -det : det) <= DET_EPS)
        begin
            res.status = ST_DEGEN;
            return;
        end
        nx = ch * dx - sr * dy;
        ny = cw * dy - sc * dx;
        if (det < 0)
        begin
            det = -det;
            nx = -nx;
            ny = -ny;
        end
        if (!pixel_position(nx, det, w, qx, rx, fx) ||
            !pixel_position(ny, det, h, qy, ry, fy))
        begin
            res.status = ST_OOB;
            return;
        end
        if (!blend)
        begin
            if (rx >= w) rx = w - 1;
            if (ry >= h) ry = h - 1;
            v = raster_copy[ry*RASTER_W + rx];
        end
        else
        begin
            gx = (longint'(1) << BLEND_BITS) - fx;
            gy = (longint'(1) << BLEND_BITS) - fy;
            x1 = (qx + 1 >= w) ? qx : qx + 1;   // far neighbor clamps at the edge
            y1 = (qy + 1 >= h) ? qy : qy + 1;
            sum = pixel_at(qx, qy) * (gx * gy)
                + pixel_at(x1, qy) * (longint'(fx) * gy)
                + pixel_at(qx, y1) * (gx * fy)
                + pixel_at(x1, y1) * (longint'(fx) * fy);
            sum = (sum + (128'sd1 <<< (2*BLEND_BITS - 1))) >>> (2*BLEND_BITS);
            v = sum[31:0];
        end
        if (g_nodata[32] && v == g_nodata[31:0])
        begin
            res.status = ST_OOB;
            return;
        end
        res.elevation = v;
    endfunction

    // map coordinate of a pixel position given in Q24 pixel units
    function automatic void map_point(input longint px, input longint py,
                                      output logic [47:0] cx, output logic [47:0] cy);
        logic signed [127:0] tx, ty, cw, ch, sr, sc;
        cw = g_cw;
        ch = g_ch;
        sr = g_sr;
        sc = g_sc;
        tx = (cw * px + sr * py) >>> 24;
        ty = (sc * px + ch * py) >>> 24;
        tx = tx + g_ox;
        ty = ty + g_oy;
        cx = tx[47:0];
        cy = ty[47:0];
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // one request on the input stream; the prediction is made at acceptance
    task automatic send_req(input logic [1:0] cmd, input logic [15:0] idx,
                            input logic [31:0] val, input logic [47:0] cx,
                            input logic [47:0] cy);
        sample_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {cy, cx, val, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cmd == CMD_LOAD)
        begin
            raster_copy[idx] = val;
            written[idx] = 1'b1;
            loads_sent++;
        end
        else
        begin
            predict_sample(cmd == CMD_BILINEAR, cx, cy, res);
            pending_results.push_back(res);
            samples_sent++;
        end
    endtask

    task automatic send_load(input int col, input int row, input logic [31:0] val);
        send_req(CMD_LOAD, 16'(row*RASTER_W + col), val, rand48(), rand48());
    endtask

    // sample at a pixel position given in 1/256 pixel
    task automatic sample_at(input logic [1:0] cmd, input longint px256,
                             input longint py256);
        logic [47:0] cx, cy;
        map_point(px256 <<< 16, py256 <<< 16, cx, cy);
        send_req(cmd, 16'($urandom), $urandom, cx, cy);
    endtask

    // lower valid and let everything in flight come out
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [47:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_ORIGIN_X:    g_ox = data;
            REG_ORIGIN_Y:    g_oy = data;
            REG_CELL_WIDTH:  g_cw = data;
            REG_CELL_HEIGHT: g_ch = data;
            REG_SKEW_ROW:    g_sr = data;
            REG_SKEW_COL:    g_sc = data;
            REG_RASTER_DIMS: g_dims = data[17:0];
            REG_NODATA_WORD: g_nodata = data[32:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // full geotransform; dims also preload every cell not yet written so
    // that no sample can reach an undefined word
    task automatic set_geometry(input logic [47:0] ox, input logic [47:0] oy,
                                input logic [47:0] cw, input logic [47:0] ch,
                                input logic [47:0] sr, input logic [47:0] sc,
                                input logic [17:0] dims);
        int w, h;
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_WIDTH, cw);
        write_reg(REG_CELL_HEIGHT, ch);
        write_reg(REG_SKEW_ROW, sr);
        write_reg(REG_SKEW_COL, sc);
        write_reg(REG_RASTER_DIMS, 48'(dims));
        w = (dims[8:0] > RASTER_W) ? RASTER_W : dims[8:0];
        h = (dims[17:9] > RASTER_H) ? RASTER_H : dims[17:9];
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                if (!written[r*RASTER_W + c])
                    send_load(c, r, $urandom);
        drain();
    endtask

    function automatic logic [17:0] dims_of(input int w, input int h);
        return {9'(h), 9'(w)};
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status=%0d elevation=%h",
                       m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== want.elevation)
                begin
                    $error("elevation: expected %h, got %h",
                           want.elevation, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset geotransform: only points off the raster, nothing loaded yet
    task automatic test_reset_state();
        send_req(CMD_NEAREST, '0, '0, -48'sd16777216, 48'sd16777216);
        send_req(CMD_BILINEAR, '0, '0, 48'sd16777216, 48'sd8589934592);
        drain();
    endtask

    // 8 x 6 north-up unit-cell raster: corners, rounding, clamping, blend, nodata
    task automatic test_directed_samples();
        set_geometry('0, 48'(6) << 24, 48'(1) << 24, -(48'(1) << 24), '0, '0,
                     dims_of(8, 6));
        send_load(0, 0, 32'h8000_0000);
        send_load(7, 5, 32'h7FFF_FFFF);
        send_load(1, 0, 32'h0000_0100);
        send_load(0, 1, 32'hFFFF_FF00);
        send_load(1, 1, 32'h1234_5678);
        sample_at(CMD_NEAREST, 0, 0);                 // top left corner
        sample_at(CMD_NEAREST, 8*256 - 1, 6*256 - 1); // rounds past last col/row
        sample_at(CMD_NEAREST_ALT, 128, 128);         // exact half rounds up
        sample_at(CMD_NEAREST, 127, 127);
        sample_at(CMD_BILINEAR, 64, 192);             // four-neighbor blend
        sample_at(CMD_BILINEAR, 128, 128);
        sample_at(CMD_BILINEAR, 7*256 + 128, 5*256 + 77); // far neighbor clamps
        sample_at(CMD_BILINEAR, 0, 0);
        sample_at(CMD_NEAREST, -1, 0);                // just off each side
        sample_at(CMD_NEAREST, 8*256, 0);
        sample_at(CMD_BILINEAR, 0, -1);
        sample_at(CMD_BILINEAR, 0, 6*256);
        drain();
        write_reg(REG_NODATA_WORD, 48'h1_1234_5678);  // matches pixel (1,1)
        sample_at(CMD_NEAREST, 256, 256);
        sample_at(CMD_BILINEAR, 256, 256);
        sample_at(CMD_NEAREST, 0, 0);
        drain();
        write_reg(REG_NODATA_WORD, 48'h0_1234_5678);  // same value, check off
        sample_at(CMD_NEAREST, 256, 256);
        drain();
    endtask

    // determinant at and just above the threshold, positive, exactly zero
    task automatic test_degenerate();
        set_geometry('0, '0, 48'd28147, 48'd1, '0, '0, dims_of(8, 6));
        send_req(CMD_NEAREST, '0, '0, 48'd56294, 48'(3) << 24);
        drain();
        set_geometry('0, '0, 48'd28148, 48'd1, '0, '0, dims_of(8, 6));
        send_req(CMD_NEAREST, '0, '0, 48'd56296, 48'(3) << 24);
        send_req(CMD_BILINEAR, '0, '0, 48'd70370, 48'(3) << 24);
        drain();
        set_geometry('0, '0, 48'(1) << 24, 48'(1) << 24, '0, '0, dims_of(8, 6));
        sample_at(CMD_BILINEAR, 300, 500);            // positive determinant
        drain();
        set_geometry('0, '0, 48'(1) << 24, 48'(2) << 24, 48'(2) << 24, 48'(1) << 24,
                     dims_of(8, 6));
        send_req(CMD_NEAREST, '0, '0, '0, '0);        // skew cancels the scale
        drain();
    endtask

    // zero and saturated raster sizes, register extremes
    task automatic test_dims_and_extremes();
        set_geometry('0, 48'(6) << 24, 48'(1) << 24, -(48'(1) << 24), '0, '0,
                     dims_of(0, 6));
        sample_at(CMD_NEAREST, 0, 0);
        drain();
        set_geometry('0, 48'(1) << 24, 48'(1) << 24, -(48'(1) << 24), '0, '0,
                     dims_of(511, 1));
        sample_at(CMD_NEAREST, 255*256 + 200, 10);
        sample_at(CMD_BILINEAR, 255*256 + 200, 10);
        drain();
        set_geometry('0, 48'(256) << 24, 48'(1) << 24, -(48'(1) << 24), '0, '0,
                     18'h3FE01);
        sample_at(CMD_BILINEAR, 10, 255*256 + 220);
        sample_at(CMD_NEAREST, 10, 255*256 + 220);
        drain();
        // extreme singular transform: every sample is degenerate, no pixel read
        write_reg(REG_ORIGIN_X, 48'h8000_0000_0000);
        write_reg(REG_ORIGIN_Y, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_CELL_WIDTH, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_CELL_HEIGHT, 48'h8000_0000_0000);
        write_reg(REG_SKEW_ROW, 48'h8000_0000_0000);
        write_reg(REG_SKEW_COL, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_RASTER_DIMS, 48'h3FFFF);
        send_req(CMD_NEAREST, 16'hFFFF, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                 48'h8000_0000_0000);
        send_req(CMD_BILINEAR, '0, '0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
        drain();
        write_reg(REG_NODATA_WORD, 48'h1_FFFF_FFFF);
        write_reg(REG_NODATA_WORD, '0);
    endtask

    // random geotransform, small raster, and a mix of loads and samples
    task automatic random_setting(input int n_items);
        int          w, h, pick;
        logic [47:0] cw, ch, sr, sc, cx, cy;
        longint      px, py;
        w = $urandom_range(12, 1);
        h = $urandom_range(12, 1);
        if ($urandom_range(19) == 0) w = 0;
        cw = 48'($urandom_range(1 << 29, 1 << 18));
        ch = 48'($urandom_range(1 << 29, 1 << 18));
        if ($urandom_range(1)) cw = -cw;
        if ($urandom_range(3) != 0) ch = -ch;
        sr = '0;
        sc = '0;
        if ($urandom_range(1))
        begin
            sr = 48'(longint'($urandom_range(1 << 23)) - (1 << 22));
            sc = 48'(longint'($urandom_range(1 << 23)) - (1 << 22));
        end
        if ($urandom_range(11) == 0)
        begin
            sr = cw;      // singular transform
            sc = ch;
        end
        set_geometry(48'(longint'($urandom_range(1 << 30)) << 12) ^
                     ($urandom_range(1) ? 48'hFFFF_0000_0000 : '0),
                     rand48() >>> 4, cw, ch, sr, sc, dims_of(w, h));
        if ($urandom_range(99) < 35 && w > 0)
            write_reg(REG_NODATA_WORD, 48'({1'b1,
                raster_copy[$urandom_range(h-1)*RASTER_W + $urandom_range(w-1)]}));
        else
            write_reg(REG_NODATA_WORD, 48'({1'($urandom), 32'($urandom)}));
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                if (w > 0 && $urandom_range(1))
                    send_load($urandom_range(w-1), $urandom_range(h-1), $urandom);
                else
                    send_req(CMD_LOAD, 16'($urandom), $urandom, rand48(), rand48());
            end
            else if (pick < 90)
            begin
                // mostly inside, a margin of one pixel around the raster
                px = longint'($urandom_range((w + 2) << 12)) - 4096;
                py = longint'($urandom_range((h + 2) << 12)) - 4096;
                map_point(px <<< 12, py <<< 12, cx, cy);
                send_req(2'($urandom_range(3, 1)), 16'($urandom), $urandom, cx, cy);
            end
            else
                send_req(2'($urandom_range(3, 1)), 16'($urandom), $urandom,
                         rand48(), rand48());
        end
        drain();
    endtask

    task automatic test_random_traffic(input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        for (int s = 0; s < 3; s++)
            random_setting(55);
    endtask

    // receiver holds off while requests keep coming: input must back up
    task automatic test_output_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        set_geometry('0, 48'(6) << 24, 48'(1) << 24, -(48'(1) << 24), '0, '0,
                     dims_of(8, 6));
        hold_cycles = 600;
        for (int i = 0; i < 20; i++)
            sample_at(2'($urandom_range(3, 1)), $urandom_range(8*256 - 1),
                      $urandom_range(6*256 - 1));
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        errors        = 0;
        loads_sent    = 0;
        samples_sent  = 0;
        results_seen  = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        cycle_count   = 0;
        g_ox     = '0;
        g_oy     = 48'sd4294967296;
        g_cw     = 48'sd16777216;
        g_ch     = -48'sd16777216;
        g_sr     = '0;
        g_sc     = '0;
        g_dims   = 18'd131328;
        g_nodata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_directed_samples();
        test_degenerate();
        test_dims_and_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(79, 0);
        test_random_traffic(0, 79);
        test_random_traffic(36, 36);
        test_output_backpressure();

        $display("Covered %0d loads and %0d samples (%0d results checked)",
                 loads_sent, samples_sent, results_seen);
        $display("nearest/bilinear, degenerate, bounds, nodata, size limits, stalls");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/arb_pkg.sv
hw/rtl/arb_mac.sv
hw/rtl/arb_div.sv
hw/rtl/affine_raster_bilinear_sampler_core.sv
tb/sv/tb_top.sv
